FILE: rtl/bayer_dpcm_bit_decoder_assert.svh
// Assertion macros for the Bayer DPCM bit decoder.
`ifndef BAYER_DPCM_BIT_DECODER_ASSERT_SVH
`define BAYER_DPCM_BIT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define BDPCM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bdpcm assertion failed");
`define BDPCM_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("bdpcm forbidden condition");
`else
`define BDPCM_ASSERT(name, prop)
`define BDPCM_NEVER(name, expr)
`endif
`endif

FILE: rtl/bdpcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bdpcm_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned WREG_W        = 11;
  localparam int unsigned HREG_W        = 13;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned COL_W         = 11;
  localparam int unsigned BUF_BITS      = 17;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned MAX_RESULTS   = 8;
  localparam int unsigned DEF_WIDTH     = 640;
  localparam int unsigned DEF_HEIGHT    = 480;
  localparam int unsigned MIN_WIDTH     = 6;
  localparam int unsigned MIN_HEIGHT    = 2;
  localparam int unsigned MAX_HEIGHT    = 4096;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] compressed_byte;
    logic       start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       end_of_frame;
    logic       last_of_item;
  } out_item_t;

  typedef struct packed {
    logic [WREG_W-1:0] width;
    logic [HREG_W-1:0] height;
    logic              width_wr;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/bdpcm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module bdpcm_cfg #(
  parameter int unsigned MAX_WIDTH = bdpcm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output bdpcm_pkg::cfg_t        cfg_o
);
  import bdpcm_pkg::*;

  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WREG_W'(DEF_WIDTH);
      height_q <= HREG_W'(DEF_HEIGHT);
    end else if (wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[WREG_W-1:0];
      end else begin
        height_q <= pwdata[HREG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_HEIGHT) begin
      prdata = 32'(height_q);
    end else begin
      prdata = 32'(width_q);
    end
  end

  always_comb begin
    if (width_q < WREG_W'(MIN_WIDTH)) begin
      cfg_o.width = WREG_W'(MIN_WIDTH);
    end else if (14'(width_q) > 14'(MAX_WIDTH)) begin
      cfg_o.width = WREG_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q < HREG_W'(MIN_HEIGHT)) begin
      cfg_o.height = HREG_W'(MIN_HEIGHT);
    end else if (height_q > HREG_W'(MAX_HEIGHT)) begin
      cfg_o.height = HREG_W'(MAX_HEIGHT);
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.width_wr = wr && (paddr[2] == REG_WIDTH);
  end

endmodule
`default_nettype wire

FILE: rtl/bdpcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bdpcm_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire bdpcm_pkg::in_item_t  in_data_i,
  output logic                      q_valid_o,
  output bdpcm_pkg::in_item_t       q_data_o,
  input  wire logic                 q_pop_i
);
  import bdpcm_pkg::*;

  in_item_t   slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bdpcm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module bdpcm_engine #(
  parameter int unsigned MAX_WIDTH = bdpcm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bdpcm_pkg::cfg_t      cfg_i,
  input  wire logic                 q_valid_i,
  input  wire bdpcm_pkg::in_item_t  q_data_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output bdpcm_pkg::out_item_t      out_data_o
);
  import bdpcm_pkg::*;
  `include "bayer_dpcm_bit_decoder_assert.svh"

  localparam int unsigned HD    = 2 * MAX_WIDTH + 2;
  localparam int unsigned PW    = $clog2(HD);
  localparam int unsigned MW    = $clog2(HD + 1);
  localparam int unsigned PRW   = ROW_W + WREG_W;
  localparam int unsigned KW    = $clog2(PRW + 1);
  localparam logic [19:0] DIV3_MUL   = 20'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  localparam logic [2:0] C3_MINUS3  = 3'b110;
  localparam logic [2:0] C3_PLUS3   = 3'b101;
  localparam logic [3:0] C4_PLUS8   = 4'b1000;
  localparam logic [3:0] C4_MINUS8  = 4'b1001;
  localparam logic [3:0] C4_MINUS20 = 4'b1111;
  localparam logic [4:0] C5_PLUS20  = 5'b11100;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MOD, S_DEC, S_RD, S_CALC, S_EMIT
  } state_e;

  state_e                st_q, st_d;
  logic [BUF_BITS-1:0]   buf_q, buf_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [PW-1:0]         p_q, p_d;
  logic [3:0]            n_q, n_d;
  logic                  recalc_q, recalc_d;
  logic [PRW-1:0]        prod_q, prod_d;
  logic [MW-1:0]         rem_q, rem_d;
  logic [KW-1:0]         k_q, k_d;
  logic [2:0]            rc_q, rc_d;
  logic [7:0]            h_q [4];
  logic [7:0]            h_d [4];
  logic [3:0]            len_q, len_d;
  logic signed [9:0]     dval_q, dval_d;
  logic [7:0]            fixed_q, fixed_d;
  logic                  fixedf_q, fixedf_d;
  logic [7:0]            pix_q, pix_d;
  logic                  eof_q, eof_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic [7:0]            hist [HD];
  logic [7:0]            rd_data_q;
  logic [PW-1:0]         rd_addr;
  logic                  wr_en;

  logic [WREG_W-1:0]     w;
  logic [HREG_W-1:0]     h;
  logic [MW-1:0]         m;
  logic                  raw;
  logic [BUF_BITS+9:0]   aligned;
  logic [9:0]            t10;
  logic [3:0]            dec_len;
  logic signed [9:0]     dec_dval;
  logic                  dec_fixedf;
  logic [7:0]            dec_fixed;
  logic [MW:0]           a2, a4, am2;
  logic [7:0]            lp, tp, tlp, trp;
  logic                  right_ok, edge_cols;
  logic [9:0]            s_edge, s_mid, s3;
  logic [19:0]           q3;
  logic [7:0]            pred;
  logic signed [10:0]    sum;
  logic [7:0]            pix;
  logic                  eof;
  logic [CNT_W-1:0]      cnt_n;
  logic [MW:0]           r2;
  logic [BUF_BITS-1:0]   base_buf;
  logic [CNT_W-1:0]      base_cnt;
  logic                  last;

  assign w   = cfg_i.width;
  assign h   = cfg_i.height;
  assign m   = MW'({2'b00, w, 1'b0} + 14'd2);
  assign raw = (row_q < ROW_W'(2)) && (col_q < COL_W'(2));

  assign aligned = {buf_q, 10'b0} >> cnt_q;
  assign t10     = aligned[9:0];

  always_comb begin
    dec_len    = 4'd0;
    dec_dval   = 10'sd0;
    dec_fixedf = 1'b0;
    dec_fixed  = {t10[4:0], 3'b000};
    if (raw) begin
      dec_fixedf = 1'b1;
      dec_fixed  = t10[9:2];
      if (cnt_q >= CNT_W'(8)) begin
        dec_len = 4'd8;
      end
    end else if (cnt_q >= CNT_W'(1)) begin
      if (!t10[9]) begin
        dec_len = 4'd1;
      end else if (cnt_q >= CNT_W'(3)) begin
        if (t10[9:7] == C3_MINUS3) begin
          dec_len  = 4'd3;
          dec_dval = -10'sd3;
        end else if (t10[9:7] == C3_PLUS3) begin
          dec_len  = 4'd3;
          dec_dval = 10'sd3;
        end else if (cnt_q >= CNT_W'(4)) begin
          if (t10[9:6] == C4_PLUS8) begin
            dec_len  = 4'd4;
            dec_dval = 10'sd8;
          end else if (t10[9:6] == C4_MINUS8) begin
            dec_len  = 4'd4;
            dec_dval = -10'sd8;
          end else if (t10[9:6] == C4_MINUS20) begin
            dec_len  = 4'd4;
            dec_dval = -10'sd20;
          end else if (cnt_q >= CNT_W'(5)) begin
            if (t10[9:5] == C5_PLUS20) begin
              dec_len  = 4'd5;
              dec_dval = 10'sd20;
            end else if (cnt_q >= CNT_W'(10)) begin
              dec_len    = 4'd10;
              dec_fixedf = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    a2 = (MW+1)'(p_q) + (MW+1)'(2);
    if (a2 >= (MW+1)'(m)) a2 = a2 - (MW+1)'(m);
    a4 = (MW+1)'(p_q) + (MW+1)'(4);
    if (a4 >= (MW+1)'(m)) a4 = a4 - (MW+1)'(m);
    if (p_q >= PW'(2)) begin
      am2 = (MW+1)'(p_q) - (MW+1)'(2);
    end else begin
      am2 = (MW+1)'(p_q) + (MW+1)'(m) - (MW+1)'(2);
    end
    case (rc_q)
      3'd0:    rd_addr = p_q;
      3'd1:    rd_addr = PW'(a2);
      3'd2:    rd_addr = PW'(a4);
      default: rd_addr = PW'(am2);
    endcase
  end

  assign tlp       = h_q[0];
  assign tp        = h_q[1];
  assign lp        = h_q[3];
  assign right_ok  = ({1'b0, col_q} + 12'd2) < {1'b0, w};
  assign edge_cols = !right_ok;
  assign trp       = right_ok ? h_q[2] : 8'd0;
  assign s_edge    = 10'(tp) + 10'(lp) + 10'(tlp) + 10'd1;
  assign s_mid     = 10'(lp) + 10'(tp) + 10'(tlp >> 1) + 10'(trp >> 1) + 10'd1;
  assign s3        = edge_cols ? s_edge : s_mid;
  assign q3        = (20'(s3) * DIV3_MUL) >> DIV3_SHIFT;

  always_comb begin
    if (row_q < ROW_W'(2)) begin
      pred = lp;
    end else if (col_q < COL_W'(2)) begin
      pred = 8'((9'(tp) + 9'(trp)) >> 1);
    end else begin
      pred = q3[7:0];
    end
    sum = $signed({3'b000, pred}) + 11'(dval_q);
    if (fixedf_q) begin
      pix = fixed_q;
    end else if (sum < 11'sd0) begin
      pix = 8'd0;
    end else if (sum > 11'sd255) begin
      pix = 8'd255;
    end else begin
      pix = sum[7:0];
    end
  end

  assign eof   = (({1'b0, col_q} + 12'd1) >= {1'b0, w})
              && (({1'b0, row_q} + 13'd1) >= h);
  assign cnt_n = cnt_q - CNT_W'(len_q);
  assign r2    = {rem_q, prod_q[PRW-1]};
  assign wr_en = (st_q == S_CALC);
  assign last  = eof_q || (n_q == 4'(MAX_RESULTS)) || (dec_len == 4'd0);

  assign base_buf = q_data_i.start_of_frame ? '0 : buf_q;
  assign base_cnt = q_data_i.start_of_frame ? '0 : cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist[p_q] <= pix;
    end
    rd_data_q <= hist[rd_addr];
  end

  always_comb begin
    st_d        = st_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    p_d         = p_q;
    n_d         = n_q;
    recalc_d    = recalc_q | cfg_i.width_wr;
    prod_d      = prod_q;
    rem_d       = rem_q;
    k_d         = k_q;
    rc_d        = rc_q;
    h_d         = h_q;
    len_d       = len_q;
    dval_d      = dval_q;
    fixed_d     = fixed_q;
    fixedf_d    = fixedf_q;
    pix_d       = pix_q;
    eof_d       = eof_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    q_pop_o     = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          n_d     = 4'd0;
          buf_d   = {base_buf[BUF_BITS-9:0], q_data_i.compressed_byte};
          cnt_d   = (base_cnt + CNT_W'(8) > CNT_W'(BUF_BITS))
                  ? CNT_W'(BUF_BITS) : base_cnt + CNT_W'(8);
          if (q_data_i.start_of_frame) begin
            row_d    = '0;
            col_d    = '0;
            p_d      = '0;
            recalc_d = 1'b0;
            st_d     = S_DEC;
          end else if (recalc_q) begin
            recalc_d = 1'b0;
            st_d     = S_MUL;
          end else begin
            st_d = S_DEC;
          end
        end
      end
      S_MUL: begin
        prod_d = PRW'(row_q) * PRW'(w) + PRW'(col_q);
        rem_d  = '0;
        k_d    = KW'(PRW);
        st_d   = S_MOD;
      end
      S_MOD: begin
        rem_d  = (r2 >= (MW+1)'(m)) ? MW'(r2 - (MW+1)'(m)) : MW'(r2);
        prod_d = prod_q << 1;
        k_d    = k_q - KW'(1);
        if (k_q == KW'(1)) begin
          p_d  = PW'(rem_d);
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        if (dec_len == 4'd0) begin
          st_d = S_IDLE;
        end else begin
          len_d    = dec_len;
          dval_d   = dec_dval;
          fixed_d  = dec_fixed;
          fixedf_d = dec_fixedf;
          rc_d     = 3'd0;
          st_d     = S_RD;
        end
      end
      S_RD: begin
        if (rc_q != 3'd0) begin
          h_d[2'(rc_q - 3'd1)] = rd_data_q;
        end
        rc_d = rc_q + 3'd1;
        if (rc_q == 3'd4) begin
          st_d = S_CALC;
        end
      end
      S_CALC: begin
        pix_d = pix;
        eof_d = eof;
        n_d   = n_q + 4'd1;
        cnt_d = cnt_n;
        buf_d = buf_q & ~({BUF_BITS{1'b1}} << cnt_n);
        if (eof) begin
          buf_d = '0;
          cnt_d = '0;
          row_d = '0;
          col_d = '0;
          p_d   = '0;
        end else begin
          if (({1'b0, col_q} + 12'd1) >= {1'b0, w}) begin
            col_d = '0;
            row_d = row_q + ROW_W'(1);
          end else begin
            col_d = col_q + COL_W'(1);
          end
          if ((MW'(p_q) + MW'(1)) >= m) begin
            p_d = '0;
          end else begin
            p_d = p_q + PW'(1);
          end
        end
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.pixel_value  = pix_q;
          out_d.end_of_frame = eof_q;
          out_d.last_of_item = last;
          st_d               = last ? S_IDLE : S_DEC;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      buf_q       <= '0;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      p_q         <= '0;
      n_q         <= '0;
      recalc_q    <= 1'b0;
      prod_q      <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      rc_q        <= '0;
      h_q         <= '{default: '0};
      len_q       <= '0;
      dval_q      <= '0;
      fixed_q     <= '0;
      fixedf_q    <= 1'b0;
      pix_q       <= '0;
      eof_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      p_q         <= p_d;
      n_q         <= n_d;
      recalc_q    <= recalc_d;
      prod_q      <= prod_d;
      rem_q       <= rem_d;
      k_q         <= k_d;
      rc_q        <= rc_d;
      h_q         <= h_d;
      len_q       <= len_d;
      dval_q      <= dval_d;
      fixed_q     <= fixed_d;
      fixedf_q    <= fixedf_d;
      pix_q       <= pix_d;
      eof_q       <= eof_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BDPCM_NEVER(a_cnt_range, cnt_q > CNT_W'(BUF_BITS))
  `BDPCM_NEVER(a_result_cap, n_q > 4'(MAX_RESULTS))
  `BDPCM_ASSERT(a_ptr_in_ring, (st_q == S_DEC) |-> (MW'(p_q) < m))
  `BDPCM_ASSERT(a_eof_rewind, (st_q == S_CALC && eof) |=> (row_q == '0 && col_q == '0))

endmodule
`default_nettype wire

FILE: rtl/bayer_dpcm_bit_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Bayer DPCM bit decoder: compressed bytes enter MSB first, one transfer each, and
// each complete prefix code leaves as one 8-bit pixel in raster order. A two-entry
// input queue decouples byte intake from the decode sequencer. Each pixel passes
// through the sequencer steps in order (decode, four reads of the history ring,
// compute, output) and holds in its output step while the output is stalled. A
// byte yields zero to eight pixels. After a frame_width write mid-frame the first
// following byte first rebuilds the ring pointer with a bit-serial remainder.
module bayer_dpcm_bit_decoder #(
  parameter int unsigned MAX_WIDTH = bdpcm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire bdpcm_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output bdpcm_pkg::out_item_t      out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);
  import bdpcm_pkg::*;

  cfg_t     cfg;
  logic     q_valid;
  in_item_t q_data;
  logic     q_pop;

  bdpcm_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdpcm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  bdpcm_engine #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
